// File: rtl/itoa_pad_pkg.sv
// Shared types, constants and widths for the padded decimal text converter.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pad_pkg;

  localparam int VALUE_W    = 32;
  localparam int CFG_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int MAX_WIDTH  = 16;
  localparam int DIGITS     = 10;
  localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int BCD_W      = 4 * DIGITS;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0]  MIN_WIDTH_RESET = CFG_W'(6);
  localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/itoa_pad_front.sv
// Input stage: takes a value, splits it into sign and unsigned magnitude.
`timescale 1ns / 1ps
`default_nettype none
module itoa_pad_front
  import itoa_pad_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [VALUE_W-1:0] s_axis_tdata,
  output item_t                   q_item,
  output logic                    q_push,
  input  wire logic               q_full
);

  logic  f_valid;
  logic  f_valid_next;
  item_t f_item;
  logic  s_accept;

  assign q_push        = f_valid && !q_full;
  assign s_axis_tready = !f_valid || !q_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign f_valid_next  = s_accept || (f_valid && !q_push);
  assign q_item        = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      f_item.neg <= s_axis_tdata[VALUE_W-1];
      f_item.mag <= s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/itoa_pad_queue.sv
// Two-entry queue between the input stage and the conversion engine.
`timescale 1ns / 1ps
`default_nettype none
module itoa_pad_queue
  import itoa_pad_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       empty
);

  item_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      priority if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/itoa_pad_back.sv
// Conversion engine: serial binary to BCD, then padded character output.
`timescale 1ns / 1ps
`default_nettype none
module itoa_pad_back
  import itoa_pad_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire item_t             q_item,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic [CNT_W-1:0]  width,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [CHAR_W-1:0]      m_axis_tdata,
  output logic                   m_axis_tlast
);

  back_state_t          state;
  back_state_t          state_next;
  logic [VALUE_W-1:0]   sh;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_next;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 neg;
  logic [CNT_W-1:0]     pad;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     nd;
  logic [CNT_W-1:0]     len;
  logic [CNT_W-1:0]     di;
  logic [3:0]           digit;
  logic [CHAR_W-1:0]    char_sel;
  logic                 last_sel;
  logic                 out_free;
  logic                 emit;
  logic                 conv_done;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign conv_done = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));
  assign last_sel  = (k == total - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_CONV;
      ST_CONV: if (conv_done) state_next = ST_SCAN;
      ST_SCAN: state_next = ST_EMIT;
      ST_EMIT: if (out_free && last_sel) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == ST_IDLE) && !q_empty;
    emit  = (state == ST_EMIT) && out_free;
  end

  always_comb begin
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[BCD_W-2:0], sh[VALUE_W-1]};
  end

  always_comb begin
    nd = CNT_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        nd = CNT_W'(i + 1);
      end
    end
    len = nd + CNT_W'(neg);
  end

  always_comb begin
    di    = total - CNT_W'(1) - k;
    digit = 4'd0;
    for (int i = 0; i < DIGITS; i++) begin
      if (di == CNT_W'(i)) begin
        digit = bcd[i*4 +: 4];
      end
    end
    priority if (k < pad) begin
      char_sel = CHAR_SPACE;
    end else if (neg && (k == pad)) begin
      char_sel = CHAR_MINUS;
    end else begin
      char_sel = CHAR_ZERO + CHAR_W'(digit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sh      <= q_item.mag;
      neg     <= q_item.neg;
      bcd     <= '0;
      bit_cnt <= '0;
    end
    if (state == ST_CONV) begin
      bcd     <= bcd_next;
      sh      <= {sh[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if (state == ST_SCAN) begin
      pad   <= (width > len) ? (width - len) : '0;
      total <= (width > len) ? width : len;
      k     <= '0;
    end
    if (emit) begin
      k            <= k + CNT_W'(1);
      m_axis_tdata <= char_sel;
      m_axis_tlast <= last_sel;
    end
  end

endmodule
`default_nettype wire

// File: rtl/int_to_decimal_ascii_padded_unit.sv
// Top level of the padded decimal text converter.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[31:0] value
//   m_axis    out        tdata[7:0] char_code, tlast last
//   cfg       in         data[4:0] min_width
//
// An item passes the input stage register and the queue, then the
// bit-serial BCD loop and the digit count state, and then goes out one
// character per cycle while the output is not stalled. Reset is synchronous
// and sets min_width to 6. Either side may stall: the queue lets a new value
// be taken while the engine still sends characters.
`timescale 1ns / 1ps
`default_nettype none
module int_to_decimal_ascii_padded_unit
  import itoa_pad_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [CHAR_W-1:0]       m_axis_tdata,   // [7:0] char_code
  output logic                    m_axis_tlast,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_data        // [4:0] min_width
);

  logic [CFG_W-1:0] min_width;
  logic [CNT_W-1:0] width;
  item_t            f_item;
  item_t            q_item;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;

  assign cfg_ready = 1'b1;
  assign width     = (int'(min_width) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(min_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= MIN_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_width <= cfg_data;
    end
  end

  itoa_pad_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_item        (f_item),
    .q_push        (q_push),
    .q_full        (q_full)
  );

  itoa_pad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  itoa_pad_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_item        (q_item),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .width         (width),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: rtl/itoa_pad_checker.sv
// Port-level checks for the padded decimal text converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module itoa_pad_checker
  import itoa_pad_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [CHAR_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tlast
);

  logic prev_minus;
  logic is_digit;

  assign is_digit = (m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_ZERO + CHAR_W'(9));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_minus <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      prev_minus <= (m_axis_tdata == CHAR_MINUS);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer withdrawn");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (is_digit || m_axis_tdata == CHAR_SPACE || m_axis_tdata == CHAR_MINUS))
    else $error("character outside space, minus and digits");

  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> is_digit)
    else $error("final character is not a digit");

  a_minus_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && prev_minus |-> is_digit && !(m_axis_tdata == CHAR_MINUS))
    else $error("minus sign not followed by a digit");

endmodule

bind int_to_decimal_ascii_padded_unit itoa_pad_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the padded decimal text converter.
`timescale 1ns / 1ps
module tb_top;
  import itoa_pad_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]  m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;

  text_char_t       expected_text[$];
  text_char_t       head_char;
  logic [CFG_W-1:0] field_width = MIN_WIDTH_RESET;
  bit               calm = 1'b0;
  int               errors = 0;
  int               values_sent = 0;
  int               chars_checked = 0;
  int               widths_set = 0;
  int               cycles = 0;
  int               stall_left = 0;

  int_to_decimal_ascii_padded_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void predict_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digit [DIGITS];
    int                 nd;
    int                 len;
    int                 width;
    int                 total;
    text_char_t         c;
    mag = value[VALUE_W-1] ? -value : value;
    nd = 0;
    do begin
      digit[nd] = 4'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    len = nd + value[VALUE_W-1];
    width = (field_width > MAX_WIDTH) ? MAX_WIDTH : field_width;
    total = (width > len) ? width : len;
    for (int k = 0; k < total; k++) begin
      if (k < total - len) begin
        c.code = CHAR_SPACE;
      end else if (value[VALUE_W-1] && k == total - len) begin
        c.code = CHAR_MINUS;
      end else begin
        c.code = CHAR_ZERO + digit[total-1-k];
      end
      c.last = (k == total - 1);
      expected_text.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] mag;
    if ($urandom_range(0, 3) == 0) return $urandom();
    mag = $urandom() >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] value);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_text(value);
    values_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_text();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (expected_text.size() != 0);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] width);
    wait_for_text();
    cfg_valid <= 1'b1;
    cfg_data  <= width;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    field_width = width;
    widths_set++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_width();
    send_value(32'd0);
    send_value(32'd1);
    send_value(-32'sd1);
    send_value(32'd7);
    send_value(-32'sd9);
    send_value(32'd123456);
    send_value(-32'sd12345);
    send_value(32'd1234567);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
  endtask

  task automatic test_width_extremes();
    set_width(5'd0);
    send_value(32'd0);
    send_value(-32'sd5);
    send_value(32'd42);
    set_width(5'd16);
    send_value(32'h8000_0000);
    send_value(32'd5);
    set_width(5'd31);
    send_value(32'h7FFF_FFFF);
    send_value(-32'sd1);
    set_width(5'd17);
    send_value(32'd0);
    set_width(5'd1);
    send_value(-32'sd3);
    send_value(32'd8);
    set_width(5'd10);
    send_value(32'd1000000000);
    send_value(-32'sd999999999);
  endtask

  task automatic test_random_widths();
    for (int phase = 0; phase < 6; phase++) begin
      set_width(CFG_W'($urandom_range(0, 31)));
      for (int n = 0; n < 18; n++) begin
        // Halfway through one phase the sender holds off until the output is empty.
        if (phase == 2 && n == 9) wait_for_text();
        send_value(random_value());
      end
    end
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    set_width(CFG_W'($urandom_range(0, 31)));
    for (int n = 0; n < 28; n++) send_value(random_value());
    wait_for_text();
  endtask

  always @(negedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_text.size() == 0) begin
        $error("char_code: expected none, actual %h", m_axis_tdata);
        errors++;
      end else begin
        head_char = expected_text.pop_front();
        if (m_axis_tdata !== head_char.code) begin
          $error("char_code: expected %h, actual %h", head_char.code, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== head_char.last) begin
          $error("last: expected %b, actual %b", head_char.last, m_axis_tlast);
          errors++;
        end
        chars_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $error("run did not finish within %0d cycles", LIMIT_CYCLES);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_width();
    test_width_extremes();
    test_random_widths();
    test_steady_stream();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Converted %0d values into %0d checked characters.", values_sent, chars_checked);
    $display("Used %0d width settings, from zero to beyond the maximum.", widths_set);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
